### src/sfla_pkg.sv
// Shared constants, codes and control/status structs of the free-list block allocator.
// No dependencies; used by the controller, the datapath, the top level and the checker.
`default_nettype none

package sfla_pkg;

    // Default sizes
    localparam int SIZE_CLASSES_DEF = 64;
    localparam int MAP_WORDS_DEF    = 64;
    localparam int STACK_DEPTH_DEF  = 16;

    // Fixed field widths
    localparam int IDX_W     = 12;
    localparam int LEN_W     = 7;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECYCLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_req;
        logic clr_step;
        logic chk_stacks;
        logic pop_rd;
        logic pop_addr;
        logic pop_take;
        logic push_rd;
        logic push_wr;
        logic free_setup;
        logic scan_init;
        logic map_rd;
        logic map_claim;
        logic scan_next;
        logic run_start;
        logic run_len;
        logic run_use;
        logic rec_step;
        logic rec_last;
        logic set_badlen;
        logic set_nospace;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic bad_len;
        logic idx_zero;
        logic hit;
        logic exact;
        logic map_full;
        logic scan_last;
        logic clr_last;
        logic work_full;
        logic found;
        logic run_push;
        logic rec_push;
        logic rec_close;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### src/sfla_ctrl.sv
// Sequencing state machine of the free-list block allocator.
// Depends on sfla_pkg for the command and status structs and the mode codes.
`default_nettype none

module sfla_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sfla_pkg::sts_t sts,
    output sfla_pkg::cmd_t     cmd
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_CLEAR    = 5'd0;
    localparam logic [ST_W-1:0] S_IDLE     = 5'd1;
    localparam logic [ST_W-1:0] S_DISPATCH = 5'd2;
    localparam logic [ST_W-1:0] S_ALLOC    = 5'd3;
    localparam logic [ST_W-1:0] S_POP_RD   = 5'd4;
    localparam logic [ST_W-1:0] S_POP_ADDR = 5'd5;
    localparam logic [ST_W-1:0] S_POP_TAKE = 5'd6;
    localparam logic [ST_W-1:0] S_PUSH_RD  = 5'd7;
    localparam logic [ST_W-1:0] S_PUSH_WR  = 5'd8;
    localparam logic [ST_W-1:0] S_MAP_RD   = 5'd9;
    localparam logic [ST_W-1:0] S_MAP_TAKE = 5'd10;
    localparam logic [ST_W-1:0] S_RUN_FIND = 5'd11;
    localparam logic [ST_W-1:0] S_RUN_LEN  = 5'd12;
    localparam logic [ST_W-1:0] S_RUN_USE  = 5'd13;
    localparam logic [ST_W-1:0] S_REC      = 5'd14;
    localparam logic [ST_W-1:0] S_REC_LAST = 5'd15;
    localparam logic [ST_W-1:0] S_DONE     = 5'd16;

    logic [ST_W-1:0] state_reg, state_next;
    logic [ST_W-1:0] ret_reg, ret_next;

    // Hold state and push return point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_DONE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if ((sts.mode == sfla_pkg::MODE_ALLOC || sts.mode == sfla_pkg::MODE_FREE)
                    && sts.bad_len)
                begin
                    cmd.set_badlen = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.mode == sfla_pkg::MODE_ALLOC)
                begin
                    cmd.chk_stacks = 1'b1;
                    state_next     = S_ALLOC;
                end
                else if (sts.mode == sfla_pkg::MODE_FREE)
                begin
                    if (!sts.idx_zero)
                    begin
                        cmd.free_setup = 1'b1;
                        ret_next       = S_DONE;
                        state_next     = S_PUSH_RD;
                    end
                    else
                        state_next = S_DONE;
                end
                else if (sts.mode == sfla_pkg::MODE_RECYCLE)
                    state_next = S_REC;
                else
                    state_next = S_DONE;
            end
            S_ALLOC:
            begin
                if (sts.hit)
                    state_next = S_POP_RD;
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_MAP_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_ADDR;
            end
            S_POP_ADDR:
            begin
                cmd.pop_addr = 1'b1;
                state_next   = S_POP_TAKE;
            end
            S_POP_TAKE:
            begin
                cmd.pop_take = 1'b1;
                if (sts.exact)
                    state_next = S_DONE;
                else
                begin
                    ret_next   = S_DONE;
                    state_next = S_PUSH_RD;
                end
            end
            S_PUSH_RD:
            begin
                cmd.push_rd = 1'b1;
                state_next  = S_PUSH_WR;
            end
            S_PUSH_WR:
            begin
                cmd.push_wr = 1'b1;
                state_next  = ret_reg;
            end
            S_MAP_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_MAP_TAKE;
            end
            S_MAP_TAKE:
            begin
                if (!sts.map_full)
                begin
                    cmd.map_claim = 1'b1;
                    state_next    = S_RUN_FIND;
                end
                else if (sts.scan_last)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_MAP_RD;
                end
            end
            S_RUN_FIND:
            begin
                if (!sts.work_full)
                begin
                    cmd.run_start = 1'b1;
                    state_next    = S_RUN_LEN;
                end
                else if (sts.found)
                    state_next = S_DONE;
                else if (sts.scan_last)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_MAP_RD;
                end
            end
            S_RUN_LEN:
            begin
                cmd.run_len = 1'b1;
                state_next  = S_RUN_USE;
            end
            S_RUN_USE:
            begin
                cmd.run_use = 1'b1;
                if (sts.run_push)
                begin
                    ret_next   = S_RUN_FIND;
                    state_next = S_PUSH_RD;
                end
                else
                    state_next = S_RUN_FIND;
            end
            S_REC:
            begin
                cmd.rec_step = 1'b1;
                if (sts.rec_push)
                begin
                    ret_next   = S_REC_LAST;
                    state_next = S_PUSH_RD;
                end
                else
                    state_next = S_REC_LAST;
            end
            S_REC_LAST:
            begin
                if (sts.rec_close)
                begin
                    cmd.rec_last = 1'b1;
                    ret_next     = S_DONE;
                    state_next   = S_PUSH_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sfla_dpath.sv
// Datapath of the free-list block allocator: run stacks, fill counts, bitmap store,
// run extraction, recycle grouping and the output register. Depends on sfla_pkg.
`default_nettype none

module sfla_dpath
#(
    parameter int SIZE_CLASSES = sfla_pkg::SIZE_CLASSES_DEF,
    parameter int MAP_WORDS    = sfla_pkg::MAP_WORDS_DEF,
    parameter int STACK_DEPTH  = sfla_pkg::STACK_DEPTH_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sfla_pkg::cmd_t                    cmd,
    output sfla_pkg::sts_t                         sts,
    input  wire logic [sfla_pkg::MODE_W-1:0]       in_mode,
    input  wire logic [sfla_pkg::IDX_W-1:0]        in_index,
    input  wire logic [sfla_pkg::LEN_W-1:0]        in_length,
    input  wire logic                              in_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [sfla_pkg::IDX_W-1:0]             out_index,
    output logic [sfla_pkg::STATUS_W-1:0]          out_status
);

    localparam int IW  = sfla_pkg::IDX_W;
    localparam int LW  = sfla_pkg::LEN_W;
    localparam int WB  = sfla_pkg::WORD_BITS;
    localparam int BW  = sfla_pkg::BIT_W;
    localparam int CW  = $clog2(SIZE_CLASSES);
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int AW  = $clog2(SIZE_CLASSES * STACK_DEPTH);
    localparam int MAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [MAW-1:0] LAST_WORD = MAW'(MAP_WORDS - 1);
    localparam logic [LW-1:0]  MAX_LEN   = LW'(SIZE_CLASSES);
    localparam logic [FW-1:0]  FULL_FILL = FW'(STACK_DEPTH);

    // Request
    logic [sfla_pkg::MODE_W-1:0] mode_reg;
    logic [IW-1:0] idx_reg;
    logic [LW-1:0] len_reg;
    logic          last_reg;

    // Result flags
    logic [IW-1:0] grant_reg;
    logic dropped_reg, nospace_reg, badlen_reg;

    // Stacks
    logic [FW-1:0] fill_reg [SIZE_CLASSES];
    logic [FW-1:0] fill_rd_reg;
    logic          push_ok_reg;
    logic [IW-1:0] push_start_reg;
    logic [LW-1:0] push_len_reg;
    logic [CW-1:0] sel_cls_reg;
    logic          exact_reg, hit_reg;
    logic [IW-1:0] stack_mem [SIZE_CLASSES * STACK_DEPTH];
    logic [IW-1:0] stack_q_reg;

    // Bitmap
    logic [WB-1:0]  map_mem [MAP_WORDS];
    logic [WB-1:0]  map_q_reg;
    logic [MAW-1:0] word_ptr_reg, scan_cnt_reg, hint_reg;
    logic [WB-1:0]  work_reg;
    logic [BW-1:0]  start_reg;
    logic [LW-1:0]  run_len_reg;
    logic           found_reg;

    // Recycle group
    logic [IW-1:0] gstart_reg;
    logic [LW-1:0] glen_reg;

    // Output register
    logic                          out_valid_reg;
    logic [IW-1:0]                 out_index_reg;
    logic [sfla_pkg::STATUS_W-1:0] out_status_reg;

    // Derived values
    logic [SIZE_CLASSES-1:0] nonempty;
    logic [CW-1:0] len_cls, push_cls, lg_cls;
    logic          lg_hit, exact_c;
    logic [AW-1:0] pop_addr, push_addr;
    logic [MAW-1:0] ptr_inc;
    logic [BW-1:0] start_c;
    logic [WB-1:0] shifted;
    logic [LW-1:0] run_len_c;
    logic [LW-1:0] run_end;
    logic [WB-1:0] low_mask;
    logic [IW-1:0] run_block;
    logic          run_fits;
    logic          rec_cont;
    logic [sfla_pkg::STATUS_W-1:0] status_c;

    // Find stack classes with entries and the first longer one
    always_comb
    begin
        for (int i = 0; i < SIZE_CLASSES; i++)
            nonempty[i] = (fill_reg[i] != '0);
        len_cls = CW'(len_reg - LW'(1));
        exact_c = nonempty[len_cls];
        lg_hit  = 1'b0;
        lg_cls  = '0;
        for (int i = SIZE_CLASSES - 1; i >= 0; i--)
        begin
            if (nonempty[i] && (LW'(i) >= len_reg))
            begin
                lg_hit = 1'b1;
                lg_cls = CW'(i);
            end
        end
    end

    assign push_cls  = CW'(push_len_reg - LW'(1));
    assign pop_addr  = AW'(sel_cls_reg) * AW'(STACK_DEPTH) + AW'(SW'(fill_rd_reg - FW'(1)));
    assign push_addr = AW'(push_cls) * AW'(STACK_DEPTH) + AW'(SW'(fill_rd_reg));
    assign ptr_inc   = (word_ptr_reg == LAST_WORD) ? '0 : word_ptr_reg + MAW'(1);

    // Locate the next free run in the claimed word
    always_comb
    begin
        start_c = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (!work_reg[i])
                start_c = BW'(i);
        end
        shifted   = (work_reg >> start_reg) | ~({WB{1'b1}} >> start_reg);
        run_len_c = LW'(WB);
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (shifted[i])
                run_len_c = LW'(i);
        end
        run_end   = LW'(start_reg) + run_len_reg;
        low_mask  = run_end[BW] ? {WB{1'b1}} : ((WB'(1) << run_end[BW-1:0]) - WB'(1));
        run_block = IW'(IW'(word_ptr_reg) << BW) | IW'(start_reg);
        run_fits  = !found_reg && (run_len_reg >= len_reg);
    end

    assign rec_cont = ({1'b0, idx_reg} == ((IW+1)'(gstart_reg) + (IW+1)'(glen_reg)))
                      && (glen_reg < MAX_LEN);

    // Result status, most specific first
    always_comb
    begin
        priority if (badlen_reg)
            status_c = sfla_pkg::ST_BAD_LEN;
        else if (nospace_reg)
            status_c = sfla_pkg::ST_NO_SPACE;
        else if (dropped_reg)
            status_c = sfla_pkg::ST_DROPPED;
        else
            status_c = sfla_pkg::ST_OK;
    end

    // Status to the controller
    always_comb
    begin
        sts.mode      = mode_reg;
        sts.bad_len   = (len_reg == '0) || (len_reg > MAX_LEN);
        sts.idx_zero  = (idx_reg == '0);
        sts.hit       = hit_reg;
        sts.exact     = exact_reg;
        sts.map_full  = (map_q_reg == {WB{1'b1}});
        sts.scan_last = (scan_cnt_reg == LAST_WORD);
        sts.clr_last  = (word_ptr_reg == LAST_WORD);
        sts.work_full = (work_reg == {WB{1'b1}});
        sts.found     = found_reg;
        sts.run_push  = found_reg || (run_len_reg != len_reg);
        sts.rec_push  = (glen_reg != '0) && !rec_cont;
        sts.rec_close = last_reg && (glen_reg != '0);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Stack and bitmap memories
    always_ff @(posedge clk)
    begin
        if (cmd.push_wr && push_ok_reg && (fill_rd_reg != FULL_FILL))
            stack_mem[push_addr] <= push_start_reg;
        if (cmd.pop_addr)
            stack_q_reg <= stack_mem[pop_addr];
        if (cmd.clr_step)
            map_mem[word_ptr_reg] <= (word_ptr_reg == '0) ? WB'(1) : '0;
        else if (cmd.map_claim)
            map_mem[word_ptr_reg] <= {WB{1'b1}};
        if (cmd.map_rd)
            map_q_reg <= map_mem[word_ptr_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= in_mode;
            idx_reg  <= in_index;
            len_reg  <= in_length;
            last_reg <= in_last;
        end
        if (cmd.chk_stacks)
        begin
            exact_reg   <= exact_c;
            hit_reg     <= exact_c || lg_hit;
            sel_cls_reg <= exact_c ? len_cls : lg_cls;
        end
        if (cmd.pop_rd)
            fill_rd_reg <= fill_reg[sel_cls_reg];
        else if (cmd.push_rd)
            fill_rd_reg <= fill_reg[push_cls];
        if (cmd.push_rd)
            push_ok_reg <= (push_len_reg != '0) && (push_len_reg <= MAX_LEN);
        if (cmd.map_claim)
            work_reg <= map_q_reg;
        else if (cmd.run_use)
            work_reg <= work_reg | low_mask;
        if (cmd.run_start)
            start_reg <= start_c;
        if (cmd.run_len)
            run_len_reg <= run_len_c;
        // Pick the run to push next
        priority if (cmd.pop_take)
        begin
            push_start_reg <= stack_q_reg + IW'(len_reg);
            push_len_reg   <= LW'(sel_cls_reg) + LW'(1) - len_reg;
        end
        else if (cmd.free_setup)
        begin
            push_start_reg <= idx_reg;
            push_len_reg   <= len_reg;
        end
        else if (cmd.run_use)
        begin
            push_start_reg <= run_fits ? run_block + IW'(len_reg) : run_block;
            push_len_reg   <= run_fits ? run_len_reg - len_reg : run_len_reg;
        end
        else if (cmd.rec_step || cmd.rec_last)
        begin
            push_start_reg <= gstart_reg;
            push_len_reg   <= glen_reg;
        end
        else
        begin
            push_start_reg <= push_start_reg;
            push_len_reg   <= push_len_reg;
        end
        if (cmd.out_load)
        begin
            out_index_reg  <= nospace_reg ? '0 : grant_reg;
            out_status_reg <= status_c;
        end
    end

    // Control state: fill counts, scan pointers, flags, group, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIZE_CLASSES; i++)
                fill_reg[i] <= '0;
            word_ptr_reg  <= '0;
            scan_cnt_reg  <= '0;
            hint_reg      <= '0;
            found_reg     <= 1'b0;
            grant_reg     <= '0;
            dropped_reg   <= 1'b0;
            nospace_reg   <= 1'b0;
            badlen_reg    <= 1'b0;
            gstart_reg    <= '0;
            glen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                grant_reg   <= '0;
                dropped_reg <= 1'b0;
                nospace_reg <= 1'b0;
                badlen_reg  <= 1'b0;
                found_reg   <= 1'b0;
            end
            if (cmd.set_badlen)
                badlen_reg <= 1'b1;
            if (cmd.set_nospace)
                nospace_reg <= 1'b1;
            // Pop and push bookkeeping
            if (cmd.pop_addr)
                fill_reg[sel_cls_reg] <= fill_rd_reg - FW'(1);
            if (cmd.pop_take)
                grant_reg <= stack_q_reg;
            if (cmd.push_rd && !((push_len_reg != '0) && (push_len_reg <= MAX_LEN)))
                dropped_reg <= 1'b1;
            if (cmd.push_wr && push_ok_reg)
            begin
                if (fill_rd_reg != FULL_FILL)
                    fill_reg[push_cls] <= fill_rd_reg + FW'(1);
                else
                    dropped_reg <= 1'b1;
            end
            // Word pointer for the clearing pass and the scan
            if (cmd.clr_step || cmd.scan_next)
                word_ptr_reg <= ptr_inc;
            else if (cmd.scan_init)
                word_ptr_reg <= hint_reg;
            if (cmd.scan_init)
                scan_cnt_reg <= '0;
            else if (cmd.scan_next)
                scan_cnt_reg <= scan_cnt_reg + MAW'(1);
            if (cmd.map_claim)
                hint_reg <= ptr_inc;
            if (cmd.run_use && run_fits)
            begin
                found_reg <= 1'b1;
                grant_reg <= run_block;
            end
            // Recycle grouping
            if (cmd.rec_step)
            begin
                if (glen_reg == '0)
                begin
                    if (idx_reg != '0)
                    begin
                        gstart_reg <= idx_reg;
                        glen_reg   <= LW'(1);
                    end
                end
                else if (rec_cont)
                    glen_reg <= glen_reg + LW'(1);
                else
                begin
                    gstart_reg <= (idx_reg != '0) ? idx_reg : gstart_reg;
                    glen_reg   <= (idx_reg != '0) ? LW'(1) : '0;
                end
            end
            else if (cmd.rec_last)
                glen_reg <= '0;
            // Output handshake
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

### src/segregated_free_list_block_allocator.sv
// Sequence from acceptance to the result word: a bad length goes straight to the result; a free
// with a nonzero index pushes its run, and a recycle element may push its group; an allocation
// pops the exact stack or a longer one and pushes the remainder, else it reads and claims bitmap
// words and extracts free runs, pushing what it does not use, until a run fits or no word is left.
// Throughput: one item at a time; s_axis_tready rises in the cycle after the result is loaded.
// Reset: asynchronous; a clearing pass over every bitmap word holds s_axis_tready low.
`default_nettype none

module segregated_free_list_block_allocator
#(
    parameter int SIZE_CLASSES = sfla_pkg::SIZE_CLASSES_DEF,
    parameter int MAP_WORDS    = sfla_pkg::MAP_WORDS_DEF,
    parameter int STACK_DEPTH  = sfla_pkg::STACK_DEPTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [11:0] block_index, [18:12] run_length, [23:19] zero
    input  wire logic [sfla_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] mode
    input  wire logic [sfla_pkg::MODE_W-1:0]         s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [11:0] granted_index, [15:12] zero
    output logic [sfla_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // [1:0] status
    output logic [sfla_pkg::STATUS_W-1:0]            m_axis_tuser
);

    sfla_pkg::cmd_t cmd;
    sfla_pkg::sts_t sts;
    logic [sfla_pkg::IDX_W-1:0] out_index;

    sfla_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfla_dpath
    #(
        .SIZE_CLASSES (SIZE_CLASSES),
        .MAP_WORDS    (MAP_WORDS),
        .STACK_DEPTH  (STACK_DEPTH)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_axis_tuser),
        .in_index   (s_axis_tdata[11:0]),
        .in_length  (s_axis_tdata[18:12]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (out_index),
        .out_status (m_axis_tuser)
    );

    // Pad the granted index to whole bytes
    assign m_axis_tdata = sfla_pkg::OUT_DATA_W'(out_index);

endmodule

`default_nettype wire

### src/sfla_checker.sv
// Port-level checker for the free-list block allocator, bound to the top level.
// Depends on sfla_pkg for the status codes.
`default_nettype none

module sfla_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [sfla_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input wire logic [sfla_pkg::STATUS_W-1:0]       m_axis_tuser
);

    // Hold a stalled result word
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // No space never carries a block index
    a_nospace_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sfla_pkg::ST_NO_SPACE) |-> m_axis_tdata == '0)
        else $error("no-space result carries an index");

    // Bad length never carries a block index
    a_badlen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sfla_pkg::ST_BAD_LEN) |-> m_axis_tdata == '0)
        else $error("bad-length result carries an index");

    // Keep the pad bits clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
        else $error("result pad bits set");

endmodule

bind segregated_free_list_block_allocator sfla_checker u_sfla_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
